[sv/mss_pkg.sv]
// shared types and constants for the match start slot store
// no dependencies
package mss_pkg;
    localparam int NUM_SLOTS   = 64;
    localparam int SLOT_BITS   = 6;
    localparam int OFFSET_BITS = 48;

    typedef logic [OFFSET_BITS-1:0] ofs_t;
    typedef logic [SLOT_BITS-1:0]   slot_t;

    typedef enum logic [3:0] {
        MODE_SET        = 4'd0,
        MODE_SET_UNSET  = 4'd1,
        MODE_SET_WR     = 4'd2,
        MODE_COPY       = 4'd3,
        MODE_COPY_WR    = 4'd4,
        MODE_MAKE_WR    = 4'd5,
        MODE_SET_FROM   = 4'd6,
        MODE_SET_FROM_WR = 4'd7,
        MODE_READ_REL   = 4'd8,
        MODE_READ_ABS   = 4'd9,
        MODE_READ_STORED = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } state_t;

    // per-item request held across the memory read
    typedef struct packed {
        logic [3:0] mode;
        slot_t      slot;
        slot_t      source_slot;
        ofs_t       distance;
        ofs_t       end_pos;
        ofs_t       known_pos;
    } req_t;
endpackage

[sv/mss_mem.sv]
// 48-bit by 64 entry memory with one write and one registered read port
// depends on mss_pkg
module mss_mem (
    input  logic          clk,
    input  logic          wr_en,
    input  mss_pkg::slot_t wr_addr,
    input  mss_pkg::ofs_t  wr_data,
    input  mss_pkg::slot_t rd_addr,
    output mss_pkg::ofs_t  rd_data
);
    import mss_pkg::*;

    ofs_t mem [NUM_SLOTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

[sv/match_start_slot_store_top.sv]
// match start slot store: one start-of-match operation per transfer
// the result shows after the input transfer once the read and execute states have passed
// items go one at a time through the accept, read, execute and output states;
// a held result stalls the input, and the reads of an item finish before the
// next item enters, so no forwarding is needed
// reset: flag bits clear, last offset all ones; slot memories undefined until written
module match_start_slot_store_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  mode,
    input  logic [5:0]  slot,
    input  logic [5:0]  source_slot,
    input  logic [47:0] distance,
    input  logic [47:0] end_pos,
    input  logic [47:0] known_pos,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] found_start,
    output logic        wrote,
    output logic        stashed,
    output logic        bad_distance
);
    import mss_pkg::*;

    state_t state_reg, state_next;
    req_t   req_reg;
    ofs_t   last_reg, last_next;
    logic [NUM_SLOTS-1:0] valid_reg, valid_next, wable_reg, wable_next;
    logic [NUM_SLOTS-1:0] now_reg, now_next, att_reg, att_next;
    ofs_t   start_reg, start_next;
    logic   wrote_reg, wrote_next, stashed_reg, stashed_next, bad_reg, bad_next;

    logic   slot_we, stash_we;
    ofs_t   slot_wd, stash_wd;
    slot_t  slot_ra;
    ofs_t   src_val, stash_val;

    // slot values read at source slot for copy and stored read, else target slot
    mss_mem u_slot_mem (
        .clk(clk), .wr_en(slot_we), .wr_addr(req_reg.slot), .wr_data(slot_wd),
        .rd_addr(slot_ra), .rd_data(src_val)
    );
    mss_mem u_stash_mem (
        .clk(clk), .wr_en(stash_we), .wr_addr(req_reg.slot), .wr_data(stash_wd),
        .rd_addr(req_reg.slot), .rd_data(stash_val)
    );

    assign slot_ra = (req_reg.mode inside {MODE_COPY, MODE_COPY_WR, MODE_READ_STORED})
        ? req_reg.source_slot : req_reg.slot;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign found_start = start_reg;
    assign wrote = wrote_reg;
    assign stashed = stashed_reg;
    assign bad_distance = bad_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= '{mode, slot, source_slot, distance, end_pos, known_pos};
        end
    end

    // control and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '1;
            valid_reg <= '0;
            wable_reg <= '0;
            now_reg   <= '0;
            att_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            valid_reg <= valid_next;
            wable_reg <= wable_next;
            now_reg   <= now_next;
            att_reg   <= att_next;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        start_reg   <= start_next;
        wrote_reg   <= wrote_next;
        stashed_reg <= stashed_next;
        bad_reg     <= bad_next;
    end

    // sequencer and execute logic
    always_comb
    begin
        logic [NUM_SLOTS-1:0] nw, at;
        logic s_v, s_n, s_w, s_a, permit;
        ofs_t val;
        slot_t s;
        s = req_reg.slot;
        state_next   = state_reg;
        last_next    = last_reg;
        valid_next   = valid_reg;
        wable_next   = wable_reg;
        now_next     = now_reg;
        att_next     = att_reg;
        start_next   = start_reg;
        wrote_next   = wrote_reg;
        stashed_next = stashed_reg;
        bad_next     = bad_reg;
        slot_we  = 1'b0;
        stash_we = 1'b0;
        slot_wd  = '0;
        stash_wd = '0;
        nw = now_reg;
        at = att_reg;
        permit = 1'b0;
        val = '0;
        s_v = 1'b0;
        s_n = 1'b0;
        s_w = 1'b0;
        s_a = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next   = ST_OUT;
                start_next   = '0;
                wrote_next   = 1'b0;
                stashed_next = 1'b0;
                bad_next     = 1'b0;
                // offset change in any mode but the reads clears written-now and attempted bits
                if (req_reg.mode <= 4'd7 && req_reg.end_pos != last_reg)
                begin
                    nw = '0;
                    at = '0;
                    last_next = req_reg.end_pos;
                end
                s_v = valid_reg[s];
                s_n = nw[s];
                s_w = wable_reg[s];
                s_a = at[s];
                case (req_reg.mode) inside
                    MODE_SET, MODE_SET_UNSET, MODE_SET_WR,
                    MODE_SET_FROM, MODE_SET_FROM_WR:
                    begin
                        if (req_reg.mode == MODE_SET_FROM
                            || req_reg.mode == MODE_SET_FROM_WR)
                        begin
                            bad_next = req_reg.distance > req_reg.known_pos;
                            val = req_reg.known_pos - req_reg.distance;
                        end
                        else
                        begin
                            bad_next = req_reg.distance > req_reg.end_pos;
                            val = req_reg.end_pos - req_reg.distance;
                        end
                        if (!bad_next)
                        begin
                            valid_next[s] = 1'b1;
                            if (req_reg.mode == MODE_SET || req_reg.mode == MODE_SET_FROM)
                            begin
                                permit = 1'b1;
                            end
                            else if (req_reg.mode == MODE_SET_UNSET)
                            begin
                                permit = !s_v || s_n;
                            end
                            else
                            begin
                                permit = !s_v || s_n || s_w;
                            end
                            if (permit)
                            begin
                                wrote_next = 1'b1;
                                if (!s_n || val < src_val)
                                begin
                                    slot_we = 1'b1;
                                    slot_wd = val;
                                end
                                nw[s] = 1'b1;
                                if (req_reg.mode == MODE_SET_WR
                                    || req_reg.mode == MODE_SET_FROM_WR)
                                begin
                                    wable_next[s] = 1'b0;
                                end
                            end
                            else if (req_reg.mode != MODE_SET_UNSET)
                            begin
                                stashed_next = 1'b1;
                                if (req_reg.mode == MODE_SET_FROM_WR)
                                begin
                                    val = req_reg.known_pos;
                                end
                                if (!s_a || val < stash_val)
                                begin
                                    stash_we = 1'b1;
                                    stash_wd = val;
                                end
                                at[s] = 1'b1;
                            end
                        end
                    end
                    MODE_COPY:
                    begin
                        valid_next[s] = 1'b1;
                        nw[s] = 1'b1;
                        slot_we = 1'b1;
                        slot_wd = src_val;
                        wrote_next = 1'b1;
                    end
                    MODE_COPY_WR:
                    begin
                        valid_next[s] = 1'b1;
                        if (!s_v || s_n || s_w)
                        begin
                            slot_we = 1'b1;
                            slot_wd = src_val;
                            nw[s] = 1'b1;
                            wable_next[s] = 1'b0;
                            wrote_next = 1'b1;
                        end
                        else
                        begin
                            at[s] = 1'b1;
                            stash_we = 1'b1;
                            stash_wd = src_val;
                            stashed_next = 1'b1;
                        end
                    end
                    MODE_MAKE_WR:
                    begin
                        if (!s_n)
                        begin
                            if (s_a)
                            begin
                                slot_we = 1'b1;
                                slot_wd = stash_val;
                                nw[s] = 1'b1;
                                wrote_next = 1'b1;
                            end
                            else
                            begin
                                wable_next[s] = 1'b1;
                            end
                        end
                    end
                    MODE_READ_REL, MODE_READ_ABS:
                    begin
                        bad_next = req_reg.distance > req_reg.end_pos;
                        if (!bad_next)
                        begin
                            start_next = (req_reg.mode == MODE_READ_REL)
                                ? req_reg.end_pos - req_reg.distance
                                : req_reg.distance;
                        end
                    end
                    MODE_READ_STORED:
                    begin
                        start_next = src_val;
                    end
                    default:
                    begin
                    end
                endcase
                now_next = nw;
                att_next = at;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result never carries both a write and a stash
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(wrote && stashed))
        else $error("wrote and stashed both set");

    // bad distance never comes with a write
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bad_distance && (wrote || stashed)))
        else $error("bad distance with a write");

    // an accepted item shows its result once it has passed the read and execute states
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##3 out_valid)
        else $error("result missing after transfer");
endmodule
